### rtl/core/alarm_clock_setting_controller_unit_assert.svh
// Assertion macros for the alarm clock setting controller.
// ACSC_ASSERT_IMP: same-cycle implication, ACSC_ASSERT_NXT: next-cycle implication.
`ifndef ALARM_CLOCK_SETTING_CONTROLLER_UNIT_ASSERT_SVH
`define ALARM_CLOCK_SETTING_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ACSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acsc assertion failed");
`define ACSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acsc assertion failed");
`else
`define ACSC_ASSERT_IMP(label, clk, rst, ante, cons)
`define ACSC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/acsc_pkg.sv
package acsc_pkg;

   localparam logic [7:0]  LongPressReset   = 8'd150;
   localparam logic [10:0] IdleTimeoutReset = 11'd1500;

   localparam logic CSR_LONG_PRESS   = 1'b0;
   localparam logic CSR_IDLE_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      ACC_NONE     = 2'd0,
      ACC_SET_TIME = 2'd1,
      ACC_SNOOZE   = 2'd2,
      ACC_ARM      = 2'd3
   } acc_cmd_type;

   typedef enum logic [1:0] {
      CAN_NONE    = 2'd0,
      CAN_RINGING = 2'd1,
      CAN_DISABLE = 2'd2
   } can_cmd_type;

   typedef struct packed {
      logic       set_time_held;
      logic       set_alarm_held;
      logic       inc_pressed;
      logic       dec_pressed;
      logic       accept_pressed;
      logic       cancel_pressed;
      logic [4:0] clock_hours;
      logic [5:0] clock_minutes;
      logic [4:0] alarm_hours;
      logic [5:0] alarm_minutes;
      logic       alarm_ringing;
   } req_word_type;

   typedef struct packed {
      logic [2:0] ui_mode;
      logic [4:0] edit_hours;
      logic [5:0] edit_minutes;
      logic [1:0] accept_command;
      logic [1:0] cancel_command;
      logic [4:0] command_hours;
      logic [5:0] command_minutes;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  long_press_ticks;
      logic [10:0] idle_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic         valid;
      req_word_type word;
   } stage_type;

endpackage

### rtl/core/acsc_req_if.sv
interface acsc_req_if;
   logic                  valid;
   logic                  ready;
   acsc_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

### rtl/core/acsc_rsp_if.sv
interface acsc_rsp_if;
   logic                  valid;
   logic                  ready;
   acsc_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

### rtl/core/acsc_csr_if.sv
interface acsc_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [10:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/acsc_csr_regs.sv
module acsc_csr_regs (
   input  logic              clock,
   input  logic              reset,
   acsc_csr_if.sink          csr_ch,
   output acsc_pkg::cfg_type cfg
);

   acsc_pkg::cfg_type cfg_ff;
   acsc_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            acsc_pkg::CSR_LONG_PRESS: begin
               cfg_in.long_press_ticks = csr_ch.data[7:0];
            end
            acsc_pkg::CSR_IDLE_TIMEOUT: begin
               cfg_in.idle_timeout_ticks = csr_ch.data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks   <= acsc_pkg::LongPressReset;
         cfg_ff.idle_timeout_ticks <= acsc_pkg::IdleTimeoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/acsc_in_reg.sv
module acsc_in_reg (
   input  logic                clock,
   input  logic                reset,
   acsc_req_if.sink            req_ch,
   input  logic                advance,
   output acsc_pkg::stage_type stage
);

   logic                   valid_ff;
   logic                   valid_in;
   acsc_pkg::req_word_type word_ff;
   acsc_pkg::req_word_type word_in;
   logic                   take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign stage.valid  = valid_ff;
   assign stage.word   = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (take) begin
         valid_in = 1'b1;
         word_in  = req_ch.word;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/core/acsc_engine.sv
`include "alarm_clock_setting_controller_unit_assert.svh"

module acsc_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  acsc_pkg::cfg_type      cfg,
   input  acsc_pkg::stage_type    stage,
   input  logic                   fire,
   output acsc_pkg::rsp_word_type result
);

   typedef enum logic [2:0] {
      MODE_NORMAL     = 3'd0,
      MODE_TIME_MIN   = 3'd1,
      MODE_TIME_HOUR  = 3'd2,
      MODE_ALARM_MIN  = 3'd3,
      MODE_ALARM_HOUR = 3'd4
   } mode_type;

   localparam logic [5:0] MinuteTop = 6'd59;
   localparam logic [4:0] HourTop   = 5'd23;
   localparam logic [7:0] HoldMax   = 8'd255;

   mode_type    mode_ff, mode_in;
   logic [4:0]  edit_hour_ff, edit_hour_in;
   logic [5:0]  edit_minute_ff, edit_minute_in;
   logic [4:0]  saved_hour_ff, saved_hour_in;
   logic [5:0]  saved_minute_ff, saved_minute_in;
   logic [7:0]  time_hold_ff, time_hold_in;
   logic [7:0]  alarm_hold_ff, alarm_hold_in;
   logic [10:0] idle_ff, idle_in;
   logic [7:0]  threshold;
   acsc_pkg::acc_cmd_type acc_cmd;
   acsc_pkg::can_cmd_type can_cmd;
   logic [4:0]  cmd_hour;
   logic [5:0]  cmd_minute;
   acsc_pkg::req_word_type w;

   function automatic logic [7:0] bump_hold(input logic [7:0] cnt, input logic held);
      if (!held) begin
         return 8'd0;
      end
      return (cnt == HoldMax) ? HoldMax : cnt + 8'd1;
   endfunction

   function automatic logic [5:0] minute_up(input logic [5:0] v);
      return (v >= MinuteTop) ? 6'd0 : v + 6'd1;
   endfunction

   function automatic logic [5:0] minute_down(input logic [5:0] v);
      return (v == 6'd0 || v > MinuteTop) ? MinuteTop : v - 6'd1;
   endfunction

   function automatic logic [4:0] hour_up(input logic [4:0] v);
      return (v >= HourTop) ? 5'd0 : v + 5'd1;
   endfunction

   function automatic logic [4:0] hour_down(input logic [4:0] v);
      return (v == 5'd0 || v > HourTop) ? HourTop : v - 5'd1;
   endfunction

   assign w         = stage.word;
   assign threshold = (cfg.long_press_ticks == 8'd0) ? 8'd1 : cfg.long_press_ticks;

   always_comb begin
      mode_in         = mode_ff;
      edit_hour_in    = edit_hour_ff;
      edit_minute_in  = edit_minute_ff;
      saved_hour_in   = saved_hour_ff;
      saved_minute_in = saved_minute_ff;
      idle_in         = idle_ff;
      acc_cmd         = acsc_pkg::ACC_NONE;
      can_cmd         = acsc_pkg::CAN_NONE;
      cmd_hour        = 5'd0;
      cmd_minute      = 6'd0;

      // timeout is checked before any key of this tick
      if (idle_in != 11'd0) begin
         idle_in = idle_in - 11'd1;
         if (idle_in == 11'd0) begin
            mode_in = MODE_NORMAL;
         end
      end

      time_hold_in = bump_hold(time_hold_ff, w.set_time_held);
      if (w.set_time_held && time_hold_in >= threshold && mode_in == MODE_NORMAL) begin
         edit_hour_in   = w.clock_hours;
         edit_minute_in = w.clock_minutes;
         mode_in        = MODE_TIME_MIN;
         idle_in        = cfg.idle_timeout_ticks;
      end

      alarm_hold_in = bump_hold(alarm_hold_ff, w.set_alarm_held);
      if (w.set_alarm_held && alarm_hold_in >= threshold && mode_in == MODE_NORMAL) begin
         edit_hour_in   = w.alarm_hours;
         edit_minute_in = w.alarm_minutes;
         mode_in        = MODE_ALARM_MIN;
         idle_in        = cfg.idle_timeout_ticks;
      end

      if (w.inc_pressed) begin
         if (mode_in == MODE_TIME_MIN || mode_in == MODE_ALARM_MIN) begin
            edit_minute_in = minute_up(edit_minute_in);
            idle_in        = cfg.idle_timeout_ticks;
         end else if (mode_in == MODE_TIME_HOUR || mode_in == MODE_ALARM_HOUR) begin
            edit_hour_in = hour_up(edit_hour_in);
            idle_in      = cfg.idle_timeout_ticks;
         end
      end

      if (w.dec_pressed) begin
         if (mode_in == MODE_TIME_MIN || mode_in == MODE_ALARM_MIN) begin
            edit_minute_in = minute_down(edit_minute_in);
            idle_in        = cfg.idle_timeout_ticks;
         end else if (mode_in == MODE_TIME_HOUR || mode_in == MODE_ALARM_HOUR) begin
            edit_hour_in = hour_down(edit_hour_in);
            idle_in      = cfg.idle_timeout_ticks;
         end
      end

      if (w.accept_pressed) begin
         unique case (mode_in)
            MODE_TIME_MIN: begin
               mode_in = MODE_TIME_HOUR;
               idle_in = cfg.idle_timeout_ticks;
            end
            MODE_TIME_HOUR: begin
               acc_cmd    = acsc_pkg::ACC_SET_TIME;
               cmd_hour   = edit_hour_in;
               cmd_minute = edit_minute_in;
               mode_in    = MODE_NORMAL;
               idle_in    = 11'd0;
            end
            MODE_ALARM_MIN: begin
               mode_in = MODE_ALARM_HOUR;
               idle_in = cfg.idle_timeout_ticks;
            end
            MODE_ALARM_HOUR: begin
               saved_hour_in   = edit_hour_in;
               saved_minute_in = edit_minute_in;
               mode_in         = MODE_NORMAL;
               idle_in         = 11'd0;
            end
            default: begin
               if (w.alarm_ringing) begin
                  acc_cmd = acsc_pkg::ACC_SNOOZE;
               end else begin
                  acc_cmd    = acsc_pkg::ACC_ARM;
                  cmd_hour   = saved_hour_ff;
                  cmd_minute = saved_minute_ff;
               end
            end
         endcase
      end

      if (w.cancel_pressed) begin
         if (mode_in != MODE_NORMAL) begin
            mode_in = MODE_NORMAL;
            idle_in = 11'd0;
         end else begin
            can_cmd = w.alarm_ringing ? acsc_pkg::CAN_RINGING : acsc_pkg::CAN_DISABLE;
         end
      end

      result.ui_mode         = mode_in;
      result.edit_hours      = edit_hour_in;
      result.edit_minutes    = edit_minute_in;
      result.accept_command  = acc_cmd;
      result.cancel_command  = can_cmd;
      result.command_hours   = cmd_hour;
      result.command_minutes = cmd_minute;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_NORMAL;
         edit_hour_ff    <= 5'd0;
         edit_minute_ff  <= 6'd0;
         saved_hour_ff   <= 5'd0;
         saved_minute_ff <= 6'd0;
         time_hold_ff    <= 8'd0;
         alarm_hold_ff   <= 8'd0;
         idle_ff         <= 11'd0;
      end else if (fire) begin
         mode_ff         <= mode_in;
         edit_hour_ff    <= edit_hour_in;
         edit_minute_ff  <= edit_minute_in;
         saved_hour_ff   <= saved_hour_in;
         saved_minute_ff <= saved_minute_in;
         time_hold_ff    <= time_hold_in;
         alarm_hold_ff   <= alarm_hold_in;
         idle_ff         <= idle_in;
      end
   end

   `ACSC_ASSERT_NXT(a_commit_leaves_edit, clock, reset,
                    fire && acc_cmd == acsc_pkg::ACC_SET_TIME,
                    mode_ff == MODE_NORMAL && idle_ff == 11'd0)
   `ACSC_ASSERT_NXT(a_release_clears_hold, clock, reset, fire && !w.set_time_held,
                    time_hold_ff == 8'd0)
   `ACSC_ASSERT_NXT(a_state_holds_idle, clock, reset, !fire,
                    $stable(mode_ff) && $stable(idle_ff))

endmodule

### rtl/core/acsc_out_reg.sv
module acsc_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  acsc_pkg::rsp_word_type word,
   output logic                   free,
   acsc_rsp_if.source             rsp_ch
);

   logic                   valid_ff;
   logic                   valid_in;
   acsc_pkg::rsp_word_type word_ff;
   acsc_pkg::rsp_word_type word_in;

   assign free         = !valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.word  = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in  = word;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/core/alarm_clock_setting_controller_unit.sv
// Alarm clock setting controller: one req word is one button poll tick, and each tick
// yields exactly one rsp word with the UI mode, the edit values and any accept or cancel
// command. A new tick is taken every cycle; a word passes an input register and a result
// register, from which its response is offered, and the input side stalls only while the
// result register holds a word that rsp has not taken. The CSR port is always ready;
// register 0 is the long-press threshold (reset 150), register 1 the idle timeout in
// ticks (reset 1500, 0 disables the timeout).
module alarm_clock_setting_controller_unit (
   input logic        clock,
   input logic        reset,
   acsc_req_if.sink   req_ch,
   acsc_rsp_if.source rsp_ch,
   acsc_csr_if.sink   csr_ch
);

   acsc_pkg::cfg_type      cfg;
   acsc_pkg::stage_type    stage;
   acsc_pkg::rsp_word_type result;
   logic                   free;
   logic                   advance;

   assign advance = stage.valid && free;

   acsc_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   acsc_in_reg u_in (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   acsc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .stage  (stage),
      .fire   (advance),
      .result (result)
   );

   acsc_out_reg u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (advance),
      .word   (result),
      .free   (free),
      .rsp_ch (rsp_ch)
   );

endmodule

### tb/acsc_checker.sv
`timescale 1ns / 100ps
module acsc_checker (
   input  logic clock,
   input  logic reset,
   acsc_req_if  req_ch,
   acsc_rsp_if  rsp_ch,
   acsc_csr_if  csr_ch,
   output int   fail_count,
   output int   pending,
   output int   ticks_checked,
   output int   edit_entries,
   output int   timeouts
);

   localparam logic [2:0] MODE_NORMAL     = 3'd0;
   localparam logic [2:0] MODE_TIME_MIN   = 3'd1;
   localparam logic [2:0] MODE_TIME_HOUR  = 3'd2;
   localparam logic [2:0] MODE_ALARM_MIN  = 3'd3;
   localparam logic [2:0] MODE_ALARM_HOUR = 3'd4;

   localparam int REPORT_LIMIT = 10;

   logic [7:0]  long_press_q;
   logic [10:0] idle_timeout_q;
   logic [2:0]  mode_q;
   logic [4:0]  edit_hour_q;
   logic [5:0]  edit_min_q;
   logic [4:0]  saved_hour_q;
   logic [5:0]  saved_min_q;
   logic [7:0]  time_hold_q;
   logic [7:0]  alarm_hold_q;
   logic [10:0] idle_left_q;

   acsc_pkg::rsp_word_type due_updates[$];

   function automatic logic [7:0] held_more(input logic [7:0] cnt, input logic held);
      if (!held) return 8'd0;
      return (cnt == 8'hFF) ? 8'hFF : cnt + 8'd1;
   endfunction

   function automatic acsc_pkg::rsp_word_type predict_update(input acsc_pkg::req_word_type w);
      acsc_pkg::rsp_word_type r;
      logic [7:0]             thr;
      r = '0;
      thr = (long_press_q == 8'd0) ? 8'd1 : long_press_q;

      if (idle_left_q != 11'd0) begin
         idle_left_q = idle_left_q - 11'd1;
         if (idle_left_q == 11'd0) begin
            mode_q = MODE_NORMAL;
            timeouts++;
         end
      end

      time_hold_q = held_more(time_hold_q, w.set_time_held);
      if (w.set_time_held && time_hold_q >= thr && mode_q == MODE_NORMAL) begin
         edit_hour_q = w.clock_hours;
         edit_min_q  = w.clock_minutes;
         mode_q      = MODE_TIME_MIN;
         idle_left_q = idle_timeout_q;
         edit_entries++;
      end

      alarm_hold_q = held_more(alarm_hold_q, w.set_alarm_held);
      if (w.set_alarm_held && alarm_hold_q >= thr && mode_q == MODE_NORMAL) begin
         edit_hour_q = w.alarm_hours;
         edit_min_q  = w.alarm_minutes;
         mode_q      = MODE_ALARM_MIN;
         idle_left_q = idle_timeout_q;
         edit_entries++;
      end

      if (w.inc_pressed) begin
         if (mode_q == MODE_TIME_MIN || mode_q == MODE_ALARM_MIN) begin
            edit_min_q  = (edit_min_q >= 6'd59) ? 6'd0 : edit_min_q + 6'd1;
            idle_left_q = idle_timeout_q;
         end else if (mode_q == MODE_TIME_HOUR || mode_q == MODE_ALARM_HOUR) begin
            edit_hour_q = (edit_hour_q >= 5'd23) ? 5'd0 : edit_hour_q + 5'd1;
            idle_left_q = idle_timeout_q;
         end
      end

      if (w.dec_pressed) begin
         if (mode_q == MODE_TIME_MIN || mode_q == MODE_ALARM_MIN) begin
            edit_min_q = (edit_min_q == 6'd0 || edit_min_q > 6'd59) ? 6'd59
                                                                    : edit_min_q - 6'd1;
            idle_left_q = idle_timeout_q;
         end else if (mode_q == MODE_TIME_HOUR || mode_q == MODE_ALARM_HOUR) begin
            edit_hour_q = (edit_hour_q == 5'd0 || edit_hour_q > 5'd23) ? 5'd23
                                                                       : edit_hour_q - 5'd1;
            idle_left_q = idle_timeout_q;
         end
      end

      if (w.accept_pressed) begin
         case (mode_q)
            MODE_TIME_MIN: begin
               mode_q      = MODE_TIME_HOUR;
               idle_left_q = idle_timeout_q;
            end
            MODE_TIME_HOUR: begin
               r.accept_command  = acsc_pkg::ACC_SET_TIME;
               r.command_hours   = edit_hour_q;
               r.command_minutes = edit_min_q;
               mode_q      = MODE_NORMAL;
               idle_left_q = 11'd0;
            end
            MODE_ALARM_MIN: begin
               mode_q      = MODE_ALARM_HOUR;
               idle_left_q = idle_timeout_q;
            end
            MODE_ALARM_HOUR: begin
               saved_hour_q = edit_hour_q;
               saved_min_q  = edit_min_q;
               mode_q       = MODE_NORMAL;
               idle_left_q  = 11'd0;
            end
            default: begin
               if (w.alarm_ringing) begin
                  r.accept_command = acsc_pkg::ACC_SNOOZE;
               end else begin
                  r.accept_command  = acsc_pkg::ACC_ARM;
                  r.command_hours   = saved_hour_q;
                  r.command_minutes = saved_min_q;
               end
            end
         endcase
      end

      if (w.cancel_pressed) begin
         if (mode_q >= MODE_TIME_MIN && mode_q <= MODE_ALARM_HOUR) begin
            mode_q      = MODE_NORMAL;
            idle_left_q = 11'd0;
         end else begin
            r.cancel_command = w.alarm_ringing ? acsc_pkg::CAN_RINGING
                                               : acsc_pkg::CAN_DISABLE;
         end
      end

      r.ui_mode      = mode_q;
      r.edit_hours   = edit_hour_q;
      r.edit_minutes = edit_min_q;
      return r;
   endfunction

   function automatic string show(input acsc_pkg::rsp_word_type r);
      return $sformatf("mode %0d edit %0d:%0d acc %0d can %0d cmd %0d:%0d",
                       r.ui_mode, r.edit_hours, r.edit_minutes, r.accept_command,
                       r.cancel_command, r.command_hours, r.command_minutes);
   endfunction

   always @(posedge clock) begin
      acsc_pkg::rsp_word_type exp_w;
      acsc_pkg::rsp_word_type got;
      string                  bad;
      if (reset) begin
         long_press_q   = acsc_pkg::LongPressReset;
         idle_timeout_q = acsc_pkg::IdleTimeoutReset;
         mode_q         = MODE_NORMAL;
         edit_hour_q    = '0;
         edit_min_q     = '0;
         saved_hour_q   = '0;
         saved_min_q    = '0;
         time_hold_q    = '0;
         alarm_hold_q   = '0;
         idle_left_q    = '0;
         due_updates.delete();
         fail_count     = 0;
         ticks_checked  = 0;
         edit_entries   = 0;
         timeouts       = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == acsc_pkg::CSR_LONG_PRESS) long_press_q = csr_ch.data[7:0];
            else idle_timeout_q = csr_ch.data;
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.word;
            if (due_updates.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected rsp word: %s", $time, show(got));
            end else begin
               exp_w = due_updates.pop_front();
               ticks_checked++;
               bad = "";
               if (got.ui_mode !== exp_w.ui_mode) bad = {bad, " ui_mode"};
               if (got.edit_hours !== exp_w.edit_hours) bad = {bad, " edit_hours"};
               if (got.edit_minutes !== exp_w.edit_minutes) bad = {bad, " edit_minutes"};
               if (got.accept_command !== exp_w.accept_command) bad = {bad, " accept_command"};
               if (got.cancel_command !== exp_w.cancel_command) bad = {bad, " cancel_command"};
               if (got.command_hours !== exp_w.command_hours) bad = {bad, " command_hours"};
               if (got.command_minutes !== exp_w.command_minutes)
                  bad = {bad, " command_minutes"};
               if (bad != "") begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("%0t: rsp mismatch in%s\n   expected %s\n   actual   %s",
                              $time, bad, show(exp_w), show(got));
               end
            end
         end

         if (req_ch.valid && req_ch.ready) due_updates.push_back(predict_update(req_ch.word));
      end
      pending = due_updates.size();
   end

endmodule

### tb/alarm_clock_setting_controller_unit_tb.sv
`timescale 1ns / 100ps
module alarm_clock_setting_controller_unit_tb;

   localparam int HOLD_OFF_CYCLES = 80;

   logic clock;
   logic reset;

   acsc_req_if req_if ();
   acsc_rsp_if rsp_if ();
   acsc_csr_if csr_if ();

   int fail_count;
   int pending;
   int ticks_checked;
   int edit_entries;
   int timeouts;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off_req   = 0;
   int cur_thr        = 1;
   int hold_kind      = 0;
   int hold_left      = 0;
   int words_sent     = 0;

   alarm_clock_setting_controller_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   acsc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_if),
      .rsp_ch        (rsp_if),
      .csr_ch        (csr_if),
      .fail_count    (fail_count),
      .pending       (pending),
      .ticks_checked (ticks_checked),
      .edit_entries  (edit_entries),
      .timeouts      (timeouts)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAIL alarm_clock_setting_controller_unit");
      $finish;
   end

   // rsp side: random stalls, plus a long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req != 0) begin
            hold_off_req = 0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   function automatic acsc_pkg::req_word_type tick_word(
      input logic st, input logic sa, input logic inc, input logic dec,
      input logic acc, input logic can, input logic [4:0] ch, input logic [5:0] cm,
      input logic [4:0] ah, input logic [5:0] am, input logic ring);
      acsc_pkg::req_word_type w;
      w.set_time_held  = st;
      w.set_alarm_held = sa;
      w.inc_pressed    = inc;
      w.dec_pressed    = dec;
      w.accept_pressed = acc;
      w.cancel_pressed = can;
      w.clock_hours    = ch;
      w.clock_minutes  = cm;
      w.alarm_hours    = ah;
      w.alarm_minutes  = am;
      w.alarm_ringing  = ring;
      return w;
   endfunction

   // mostly button holds around the threshold, with random keys on top
   function automatic acsc_pkg::req_word_type random_tick();
      acsc_pkg::req_word_type w;
      if (hold_left <= 0) begin
         hold_kind = $urandom_range(0, 9);
         if (hold_kind < 4) hold_left = $urandom_range(1, 6);
         else hold_left = cur_thr + int'($urandom_range(0, 6)) - 2;
         if (hold_left < 1) hold_left = 1;
      end
      hold_left--;
      w.set_time_held  = (hold_kind >= 4 && hold_kind <= 6) || hold_kind == 9;
      w.set_alarm_held = hold_kind >= 7;
      if ($urandom_range(0, 29) == 0) w.set_time_held = ~w.set_time_held;
      if ($urandom_range(0, 29) == 0) w.set_alarm_held = ~w.set_alarm_held;
      w.inc_pressed    = $urandom_range(0, 3) == 0;
      w.dec_pressed    = $urandom_range(0, 4) == 0;
      w.accept_pressed = $urandom_range(0, 5) == 0;
      w.cancel_pressed = $urandom_range(0, 9) == 0;
      w.clock_hours    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, 23));
      w.clock_minutes  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 59));
      w.alarm_hours    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, 23));
      w.alarm_minutes  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 59));
      w.alarm_ringing  = $urandom_range(0, 2) == 0;
      return w;
   endfunction

   // called at a falling edge; leaves valid high so back-to-back words need no re-raise
   task automatic send_tick(input acsc_pkg::req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.word  <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_settings(input logic [7:0] lp, input logic [10:0] idle_to);
      settle();
      csr_if.valid <= 1'b1;
      for (int i = 0; i < 2; i++) begin
         csr_if.index <= (i == 0) ? acsc_pkg::CSR_LONG_PRESS : acsc_pkg::CSR_IDLE_TIMEOUT;
         csr_if.data  <= (i == 0) ? {3'b000, lp} : idle_to;
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
         @(negedge clock);
      end
      csr_if.valid <= 1'b0;
      cur_thr = (lp == 8'd0) ? 1 : int'(lp);
   endtask

   task automatic run_phase(input logic [7:0] lp, input logic [10:0] idle_to, input int n,
                            input int s_pct, input int r_pct, input bit squeeze);
      load_settings(lp, idle_to);
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      hold_left      = 0;
      if (squeeze) hold_off_req = 1;
      repeat (n) send_tick(random_tick());
   endtask

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.word  = '0;
      csr_if.valid = 1'b0;
      csr_if.index = acsc_pkg::CSR_LONG_PRESS;
      csr_if.data  = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // normal-mode commands at reset settings
      send_tick(tick_word(0, 0, 0, 0, 0, 0, 5'd0, 6'd0, 5'd0, 6'd0, 0));
      send_tick(tick_word(0, 0, 0, 0, 1, 0, 5'd12, 6'd30, 5'd6, 6'd45, 0));
      send_tick(tick_word(0, 0, 0, 0, 1, 0, 5'd12, 6'd31, 5'd6, 6'd45, 1));
      send_tick(tick_word(0, 0, 0, 0, 0, 1, 5'd12, 6'd32, 5'd6, 6'd45, 1));
      send_tick(tick_word(0, 0, 0, 0, 0, 1, 5'd12, 6'd33, 5'd6, 6'd45, 0));
      send_tick('1);
      send_tick(tick_word(0, 0, 1, 1, 0, 0, 5'd1, 6'd2, 5'd3, 6'd4, 0));

      // zero threshold acts as one; short timeout
      load_settings(8'd0, 11'd3);
      send_tick(tick_word(1, 0, 0, 0, 0, 0, 5'd31, 6'd63, 5'd0, 6'd0, 0));
      send_tick(tick_word(1, 0, 1, 0, 0, 0, 5'd0, 6'd0, 5'd0, 6'd0, 0));
      send_tick(tick_word(0, 0, 0, 1, 0, 0, 5'd0, 6'd0, 5'd0, 6'd0, 0));
      send_tick(tick_word(0, 0, 0, 1, 0, 0, 5'd0, 6'd0, 5'd0, 6'd0, 1));
      send_tick(tick_word(0, 0, 0, 0, 1, 0, 5'd0, 6'd0, 5'd0, 6'd0, 0));
      send_tick(tick_word(0, 0, 0, 1, 0, 0, 5'd0, 6'd0, 5'd0, 6'd0, 0));
      send_tick(tick_word(0, 0, 1, 0, 0, 0, 5'd0, 6'd0, 5'd0, 6'd0, 0));
      send_tick(tick_word(0, 0, 0, 0, 1, 0, 5'd0, 6'd0, 5'd0, 6'd0, 1));
      send_tick(tick_word(0, 1, 0, 0, 0, 0, 5'd4, 6'd5, 5'd23, 6'd59, 0));
      send_tick(tick_word(0, 1, 1, 0, 0, 0, 5'd4, 6'd5, 5'd23, 6'd59, 0));
      send_tick(tick_word(0, 1, 0, 0, 1, 0, 5'd4, 6'd5, 5'd23, 6'd59, 0));
      send_tick(tick_word(0, 1, 0, 1, 0, 0, 5'd4, 6'd5, 5'd23, 6'd59, 0));
      send_tick(tick_word(0, 1, 0, 0, 1, 0, 5'd4, 6'd5, 5'd23, 6'd59, 0));
      send_tick(tick_word(0, 0, 0, 0, 1, 0, 5'd4, 6'd5, 5'd23, 6'd59, 0));
      // both buttons: set-time wins; cancel with button held re-enters
      send_tick(tick_word(1, 1, 0, 0, 0, 0, 5'd5, 6'd6, 5'd7, 6'd8, 0));
      send_tick(tick_word(1, 0, 0, 0, 0, 1, 5'd9, 6'd10, 5'd7, 6'd8, 0));
      send_tick(tick_word(1, 0, 0, 0, 0, 0, 5'd11, 6'd12, 5'd7, 6'd8, 0));
      send_tick(tick_word(0, 0, 0, 0, 0, 0, 5'd11, 6'd12, 5'd7, 6'd8, 0));
      send_tick(tick_word(0, 0, 0, 0, 0, 0, 5'd11, 6'd12, 5'd7, 6'd8, 0));
      send_tick(tick_word(0, 0, 1, 0, 0, 0, 5'd11, 6'd12, 5'd7, 6'd8, 0));

      run_phase(8'd3,   11'd12,   400, 0,  0,  0);
      run_phase(8'd1,   11'd0,    300, 71, 0,  0);
      run_phase(8'd255, 11'd2047, 500, 0,  71, 0);
      run_phase(8'd6,   11'd1,    300, 12, 12, 0);
      run_phase(8'd2,   11'd9,    300, 0,  0,  1);

      settle();
      repeat (6) @(negedge clock);
      if (pending != 0) begin
         $display("%0d expected rsp words never arrived", pending);
      end

      $display("Sent %0d poll ticks, checked %0d rsp words over seven threshold/timeout settings.",
               words_sent, ticks_checked);
      $display("Saw %0d edit entries and %0d idle timeouts; idling none/sender/receiver/both.",
               edit_entries, timeouts);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS alarm_clock_setting_controller_unit");
      end else begin
         $display("FAIL alarm_clock_setting_controller_unit");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/acsc_pkg.sv
rtl/core/acsc_req_if.sv
rtl/core/acsc_rsp_if.sv
rtl/core/acsc_csr_if.sv
rtl/core/acsc_csr_regs.sv
rtl/core/acsc_in_reg.sv
rtl/core/acsc_engine.sv
rtl/core/acsc_out_reg.sv
rtl/core/alarm_clock_setting_controller_unit.sv
tb/acsc_checker.sv
tb/alarm_clock_setting_controller_unit_tb.sv
